// ===== src/rmms_pkg.sv =====
`timescale 1ns / 1ps

package rmms_pkg;

   // Field widths
   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS  = 24;
   localparam int TIME_BITS   = 48;
   localparam int FRAC_BITS   = 8;
   localparam int FUNC_BITS   = 2;

   // Accumulators
   localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
   localparam int SQ_BITS   = 2 * SAMPLE_BITS + COUNT_BITS - 2;
   localparam int WIDE_BITS = SAMPLE_BITS + FRAC_BITS;

   // Mean division: (|sum| << FRAC) / count, quotient below 2^WIDE_BITS
   localparam int MNUM_BITS = SUM_BITS + FRAC_BITS;
   localparam int MQ_BITS   = WIDE_BITS;

   // Mean-square division: (sumsq << 2*FRAC) / count, quotient at most 2^(2S-2+2F)
   localparam int QNUM_BITS = SQ_BITS + 2 * FRAC_BITS;
   localparam int QQ_BITS   = 2 * SAMPLE_BITS - 1 + 2 * FRAC_BITS;

   // Shared serial divider
   localparam int DIV_Q_BITS   = QQ_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_Q_BITS + 1);

   // Serial multiplier and root
   localparam int MUL_BITS      = WIDE_BITS;
   localparam int MUL_CNT_BITS  = $clog2(MUL_BITS + 1);
   localparam int PROD_BITS     = 2 * MUL_BITS;
   localparam int ROOT_BITS     = MUL_BITS;
   localparam int ROOT_CNT_BITS = $clog2(ROOT_BITS + 1);

   // Stream payloads
   localparam int REQ_DATA_BITS  = ((SAMPLE_BITS + TIME_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 2 * SAMPLE_BITS + 2 * TIME_BITS + 2 * WIDE_BITS
                                   + COUNT_BITS + 2;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // Request kinds; the unused code behaves as a report
   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_ADD    = 2'd0,
      FUNC_REPORT = 2'd1,
      FUNC_CLEAR  = 2'd2
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAUNCH_MEAN,
      ST_SQUARE,
      ST_LAUNCH_VAR,
      ST_VAR,
      ST_LAUNCH_ROOT,
      ST_ROOT,
      ST_DONE
   } state_type;

endpackage

// ===== src/rmms_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
// The caller hands in the top of the numerator (already below the divisor)
// and the remaining low bits left-aligned, plus the number of steps.
module rmms_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [rmms_pkg::COUNT_BITS-1:0]      divisor,
   input  logic [rmms_pkg::COUNT_BITS-1:0]      init_rem,
   input  logic [rmms_pkg::DIV_Q_BITS-1:0]      low_bits,
   input  logic [rmms_pkg::DIV_CNT_BITS-1:0]    steps,
   output logic [rmms_pkg::DIV_Q_BITS-1:0]      quotient,
   output logic [rmms_pkg::COUNT_BITS-1:0]      remainder,
   output logic                                 busy
);

   logic                                busy_ff;
   logic [rmms_pkg::DIV_CNT_BITS-1:0]   cnt_ff;
   logic [rmms_pkg::COUNT_BITS-1:0]     div_ff;
   logic [rmms_pkg::COUNT_BITS-1:0]     rem_ff;
   logic [rmms_pkg::DIV_Q_BITS-1:0]     bits_ff;
   logic [rmms_pkg::DIV_Q_BITS-1:0]     quo_ff;

   logic [rmms_pkg::COUNT_BITS:0]       trial;
   logic [rmms_pkg::COUNT_BITS:0]       diff;
   logic                                fits;
   logic [rmms_pkg::COUNT_BITS-1:0]     rem_in;

   // One trial subtraction per cycle
   always_comb begin
      trial  = {rem_ff, bits_ff[rmms_pkg::DIV_Q_BITS-1]};
      diff   = trial - {1'b0, div_ff};
      fits   = (trial >= {1'b0, div_ff});
      rem_in = fits ? diff[rmms_pkg::COUNT_BITS-1:0] : trial[rmms_pkg::COUNT_BITS-1:0];
   end

   // Step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= steps;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == rmms_pkg::DIV_CNT_BITS'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         div_ff  <= divisor;
         rem_ff  <= init_rem;
         bits_ff <= low_bits;
         quo_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         bits_ff <= {bits_ff[rmms_pkg::DIV_Q_BITS-2:0], 1'b0};
         quo_ff  <= {quo_ff[rmms_pkg::DIV_Q_BITS-2:0], fits};
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign busy      = busy_ff;

endmodule

// ===== src/rmms_mul.sv =====
`timescale 1ns / 1ps

// Shift-add multiplier, one multiplier bit per cycle.
module rmms_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [rmms_pkg::MUL_BITS-1:0]     mul_a,
   input  logic [rmms_pkg::MUL_BITS-1:0]     mul_b,
   output logic [rmms_pkg::PROD_BITS-1:0]    product,
   output logic                              busy
);

   logic                                busy_ff;
   logic [rmms_pkg::MUL_CNT_BITS-1:0]   cnt_ff;
   logic [rmms_pkg::MUL_BITS-1:0]       a_ff;
   logic [rmms_pkg::PROD_BITS-1:0]      prod_ff;

   logic [rmms_pkg::MUL_BITS:0]         upper_in;
   logic [rmms_pkg::PROD_BITS-1:0]      prod_in;

   // Add the multiplicand into the upper half when the low bit is set, then shift
   always_comb begin
      upper_in = {1'b0, prod_ff[rmms_pkg::PROD_BITS-1:rmms_pkg::MUL_BITS]}
                 + (prod_ff[0] ? {1'b0, a_ff} : '0);
      prod_in  = {upper_in, prod_ff[rmms_pkg::MUL_BITS-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= rmms_pkg::MUL_CNT_BITS'(rmms_pkg::MUL_BITS);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == rmms_pkg::MUL_CNT_BITS'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff    <= mul_a;
         prod_ff <= {{rmms_pkg::MUL_BITS{1'b0}}, mul_b};
      end else if (busy_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign product = prod_ff;
   assign busy    = busy_ff;

endmodule

// ===== src/rmms_sqrt.sv =====
`timescale 1ns / 1ps

// Digit-by-digit integer square root, two radicand bits per cycle.
module rmms_sqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [rmms_pkg::PROD_BITS-1:0]     radicand,
   output logic [rmms_pkg::ROOT_BITS-1:0]     root,
   output logic                               busy
);

   logic                                 busy_ff;
   logic [rmms_pkg::ROOT_CNT_BITS-1:0]   cnt_ff;
   logic [rmms_pkg::PROD_BITS-1:0]       x_ff;
   logic [rmms_pkg::ROOT_BITS:0]         rem_ff;
   logic [rmms_pkg::ROOT_BITS-1:0]       root_ff;

   logic [rmms_pkg::ROOT_BITS+2:0]       shifted;
   logic [rmms_pkg::ROOT_BITS+2:0]       trial;
   logic [rmms_pkg::ROOT_BITS+2:0]       diff;
   logic                                 fits;
   logic [rmms_pkg::ROOT_BITS:0]         rem_in;
   logic [rmms_pkg::ROOT_BITS-1:0]       root_in;

   // Bring down the next two bits and try root*4+1
   always_comb begin
      shifted = {rem_ff, x_ff[rmms_pkg::PROD_BITS-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      diff    = shifted - trial;
      fits    = (shifted >= trial);
      rem_in  = fits ? diff[rmms_pkg::ROOT_BITS:0] : shifted[rmms_pkg::ROOT_BITS:0];
      root_in = {root_ff[rmms_pkg::ROOT_BITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= rmms_pkg::ROOT_CNT_BITS'(rmms_pkg::ROOT_BITS);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == rmms_pkg::ROOT_CNT_BITS'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         x_ff    <= {x_ff[rmms_pkg::PROD_BITS-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign root = root_ff;
   assign busy = busy_ff;

endmodule

// ===== src/running_min_max_mean_stddev_core.sv =====
// Running min / max / mean / standard deviation core.
// Sequence from request acceptance to response valid: a 24-step serial square beside the
// 24-step mean division, a 47-step mean-square division (the mean is squared beside it),
// a 24-step root, with a launch state before each step and a done state at the end.
// One transaction at a time; a held response holds off the next request.
// Reset (synchronous, active high) empties the statistics and drops any response in flight.
`timescale 1ns / 1ps

module running_min_max_mean_stddev_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // sample [15:0], time_stamp [63:16]
   input  logic [rmms_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // func [1:0]
   input  logic [rmms_pkg::FUNC_BITS-1:0]        req_tuser,
   // Response stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // max_value [15:0], max_time [63:16], min_value [79:64], min_time [127:80],
   // mean_value [151:128], std_dev [175:152], sample_count [199:176],
   // is_empty [200], count_full [201], zero fill [207:202]
   output logic [rmms_pkg::RSP_DATA_BITS-1:0]    rsp_tdata
);

   localparam int S = rmms_pkg::SAMPLE_BITS;
   localparam int T = rmms_pkg::TIME_BITS;
   localparam int C = rmms_pkg::COUNT_BITS;
   localparam int W = rmms_pkg::WIDE_BITS;
   localparam int F = rmms_pkg::FRAC_BITS;

   // Request fields
   logic                           req_accept;
   logic signed [S-1:0]            req_sample;
   logic [T-1:0]                   req_time;
   rmms_pkg::func_type             req_func;

   // Statistics
   logic signed [S-1:0]            largest_ff;
   logic [T-1:0]                   largest_time_ff;
   logic signed [S-1:0]            smallest_ff;
   logic [T-1:0]                   smallest_time_ff;
   logic signed [rmms_pkg::SUM_BITS-1:0] sum_ff;
   logic [rmms_pkg::SQ_BITS-1:0]   sq_ff;
   logic [C-1:0]                   count_ff;
   logic                           dropped_ff;

   // Per-transaction working registers
   logic                           add_ff;
   logic [S-1:0]                   mag_ff;
   logic                           neg_ff;
   logic [W-1:0]                   mmag_ff;

   // Sequencer
   rmms_pkg::state_type            state_ff;
   rmms_pkg::state_type            state_in;
   logic                           launch_mean;
   logic                           fold_square;
   logic                           launch_var;
   logic                           launch_root;
   logic                           load_rsp;

   // Response register
   logic                           rsp_valid_ff;
   logic [rmms_pkg::RSP_DATA_BITS-1:0] rsp_data_ff;
   logic [rmms_pkg::RSP_DATA_BITS-1:0] rsp_in;

   // Units
   logic                           div_start;
   logic [C-1:0]                   div_init;
   logic [rmms_pkg::DIV_Q_BITS-1:0] div_low;
   logic [rmms_pkg::DIV_CNT_BITS-1:0] div_steps;
   logic [rmms_pkg::DIV_Q_BITS-1:0] div_quo;
   logic [C-1:0]                   div_rem;
   logic                           div_busy;

   logic                           mul_start;
   logic [rmms_pkg::MUL_BITS-1:0]  mul_op;
   logic [rmms_pkg::PROD_BITS-1:0] mul_prod;
   logic                           mul_busy;

   logic [rmms_pkg::PROD_BITS-1:0] var_val;
   logic [rmms_pkg::ROOT_BITS-1:0] root_val;
   logic                           sqrt_busy;

   // Datapath helpers
   logic [S-1:0]                   sample_mag;
   logic                           first_sample;
   logic [rmms_pkg::SUM_BITS-1:0]  abs_sum;
   logic [rmms_pkg::MNUM_BITS-1:0] mean_num;
   logic [rmms_pkg::QNUM_BITS-1:0] msq_num;
   logic [W-1:0]                   mmag_in;
   logic [rmms_pkg::PROD_BITS-1:0] q_ext;
   logic                           empty;
   logic [W-1:0]                   mean_out;
   logic [W-1:0]                   std_out;

   assign req_sample = req_tdata[S-1:0];
   assign req_time   = req_tdata[S+T-1:S];
   assign req_func   = rmms_pkg::func_type'(req_tuser);
   assign req_accept = req_tvalid & req_tready;

   assign sample_mag   = req_sample[S-1] ? S'(-req_sample) : S'(req_sample);
   assign first_sample = (count_ff == '0);

   // Statistics update at request acceptance; the sample's square is folded in once it is ready
   always_ff @(posedge clock) begin
      if (reset) begin
         largest_ff       <= {1'b1, {(S-1){1'b0}}};
         largest_time_ff  <= '0;
         smallest_ff      <= {1'b0, {(S-1){1'b1}}};
         smallest_time_ff <= '0;
         sum_ff           <= '0;
         sq_ff            <= '0;
         count_ff         <= '0;
         dropped_ff       <= 1'b0;
         add_ff           <= 1'b0;
      end else begin
         if (req_accept) begin
            add_ff <= 1'b0;
            unique case (req_func)
               rmms_pkg::FUNC_CLEAR: begin
                  largest_ff       <= {1'b1, {(S-1){1'b0}}};
                  largest_time_ff  <= '0;
                  smallest_ff      <= {1'b0, {(S-1){1'b1}}};
                  smallest_time_ff <= '0;
                  sum_ff           <= '0;
                  sq_ff            <= '0;
                  count_ff         <= '0;
                  dropped_ff       <= 1'b0;
               end
               rmms_pkg::FUNC_ADD: begin
                  if (count_ff == {C{1'b1}}) begin
                     dropped_ff <= 1'b1;
                  end else begin
                     if (first_sample || (req_sample > largest_ff)) begin
                        largest_ff      <= req_sample;
                        largest_time_ff <= req_time;
                     end
                     if (first_sample || (req_sample < smallest_ff)) begin
                        smallest_ff      <= req_sample;
                        smallest_time_ff <= req_time;
                     end
                     sum_ff   <= sum_ff + rmms_pkg::SUM_BITS'(req_sample);
                     count_ff <= count_ff + 1'b1;
                     add_ff   <= 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
         // Square of the new sample joins the sum of squares
         if (fold_square && add_ff) begin
            sq_ff <= sq_ff + rmms_pkg::SQ_BITS'(mul_prod);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         mag_ff <= sample_mag;
      end
      if (launch_mean) begin
         neg_ff <= sum_ff[rmms_pkg::SUM_BITS-1];
      end
      if (launch_var) begin
         mmag_ff <= mmag_in;
      end
   end

   // Mean numerator: |sum| with fraction bits
   assign abs_sum  = sum_ff[rmms_pkg::SUM_BITS-1] ? rmms_pkg::SUM_BITS'(-sum_ff)
                                                  : rmms_pkg::SUM_BITS'(sum_ff);
   assign mean_num = {abs_sum, {F{1'b0}}};
   // Mean-square numerator
   assign msq_num  = {sq_ff, {(2*F){1'b0}}};

   // Negative mean rounds its magnitude up so the signed mean floors
   assign mmag_in = div_quo[W-1:0] + W'(neg_ff && (div_rem != '0));

   // Divider operand select
   always_comb begin
      div_start = launch_mean | launch_var;
      if (launch_mean) begin
         div_init  = mean_num[rmms_pkg::MNUM_BITS-1:rmms_pkg::MQ_BITS];
         div_low   = {mean_num[rmms_pkg::MQ_BITS-1:0],
                      {(rmms_pkg::DIV_Q_BITS-rmms_pkg::MQ_BITS){1'b0}}};
         div_steps = rmms_pkg::DIV_CNT_BITS'(rmms_pkg::MQ_BITS);
      end else begin
         div_init  = C'(msq_num[rmms_pkg::QNUM_BITS-1:rmms_pkg::QQ_BITS]);
         div_low   = msq_num[rmms_pkg::QQ_BITS-1:0];
         div_steps = rmms_pkg::DIV_CNT_BITS'(rmms_pkg::QQ_BITS);
      end
   end

   // Multiplier squares the sample first, then the mean magnitude
   assign mul_start = launch_mean | launch_var;
   assign mul_op    = launch_mean ? rmms_pkg::MUL_BITS'(mag_ff) : rmms_pkg::MUL_BITS'(mmag_in);

   // Variance magnitude |Q - M*M|
   always_comb begin
      q_ext   = rmms_pkg::PROD_BITS'(div_quo);
      var_val = (q_ext >= mul_prod) ? (q_ext - mul_prod) : (mul_prod - q_ext);
   end

   rmms_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .divisor   (count_ff),
      .init_rem  (div_init),
      .low_bits  (div_low),
      .steps     (div_steps),
      .quotient  (div_quo),
      .remainder (div_rem),
      .busy      (div_busy)
   );

   rmms_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mul_a   (mul_op),
      .mul_b   (mul_op),
      .product (mul_prod),
      .busy    (mul_busy)
   );

   rmms_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (launch_root),
      .radicand (var_val),
      .root     (root_val),
      .busy     (sqrt_busy)
   );

   // Sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rmms_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rmms_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = rmms_pkg::ST_LAUNCH_MEAN;
            end
         end
         rmms_pkg::ST_LAUNCH_MEAN: state_in = rmms_pkg::ST_SQUARE;
         rmms_pkg::ST_SQUARE: begin
            if (!mul_busy && !div_busy) begin
               state_in = rmms_pkg::ST_LAUNCH_VAR;
            end
         end
         rmms_pkg::ST_LAUNCH_VAR: state_in = rmms_pkg::ST_VAR;
         rmms_pkg::ST_VAR: begin
            if (!mul_busy && !div_busy) begin
               state_in = rmms_pkg::ST_LAUNCH_ROOT;
            end
         end
         rmms_pkg::ST_LAUNCH_ROOT: state_in = rmms_pkg::ST_ROOT;
         rmms_pkg::ST_ROOT: begin
            if (!sqrt_busy) begin
               state_in = rmms_pkg::ST_DONE;
            end
         end
         rmms_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = rmms_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready  = 1'b0;
      launch_mean = 1'b0;
      fold_square = 1'b0;
      launch_var  = 1'b0;
      launch_root = 1'b0;
      load_rsp    = 1'b0;
      unique case (state_ff)
         rmms_pkg::ST_IDLE:        req_tready  = 1'b1;
         rmms_pkg::ST_LAUNCH_MEAN: launch_mean = 1'b1;
         rmms_pkg::ST_SQUARE:      fold_square = !mul_busy && !div_busy;
         rmms_pkg::ST_LAUNCH_VAR:  launch_var  = 1'b1;
         rmms_pkg::ST_VAR: begin
         end
         rmms_pkg::ST_LAUNCH_ROOT: launch_root = 1'b1;
         rmms_pkg::ST_ROOT: begin
         end
         rmms_pkg::ST_DONE:        load_rsp    = !rsp_valid_ff || rsp_tready;
      endcase
   end

   // Response assembly
   always_comb begin
      empty    = (count_ff == '0);
      mean_out = empty ? '0 : (neg_ff ? (W'(0) - mmag_ff) : mmag_ff);
      std_out  = empty ? '0 : W'(root_val);
      rsp_in   = {{(rmms_pkg::RSP_DATA_BITS-rmms_pkg::RSP_FIELD_BITS){1'b0}},
                  dropped_ff, empty, count_ff, std_out, mean_out,
                  smallest_time_ff, smallest_ff, largest_time_ff, largest_ff};
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
